/* rtl/cppd_pkg.sv */
// Shared types, constants and table builders for the pruned Collatz prefix depth block.
package cppd_pkg;

	localparam int VAL_W   = 128;
	localparam int START_W = 64;
	localparam int CELL_W  = 8;
	localparam int N_CELLS = VAL_W / CELL_W;
	localparam int DEPTH_W = 8;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic odd;
	} cell_ctl_t;

	// least q with 3^q >= 2^k, k up to 256
	function automatic logic [8:0] qmin_f(input int k);
		logic [263:0] p2;
		logic [263:0] p3;
		logic [8:0]   q;
		p2 = 264'd1 << k;
		p3 = 264'd1;
		q  = '0;
		for (int i = 0; i < 256; i++) begin
			if (p3 < p2) begin
				p3 = (p3 << 1) + p3;
				q  = q + 9'd1;
			end
		end
		return q;
	endfunction

	// residue by shift-and-subtract, small operands only
	function automatic int resid_f(input int x, input int m);
		int r;
		r = x;
		for (int s = 12; s >= 0; s--) begin
			if (r >= (m << s))
				r = r - (m << s);
		end
		return r;
	endfunction

	// popcount q and R = 3R + 2^i over set bits, ascending
	function automatic int wq_f(input int gb, input int mask);
		int q;
		q = 0;
		for (int i = 0; i < gb; i++) begin
			if (((mask >> i) & 1) != 0)
				q = q + 1;
		end
		return q;
	endfunction

	function automatic int wr_f(input int gb, input int mask);
		int r;
		r = 0;
		for (int i = 0; i < gb; i++) begin
			if (((mask >> i) & 1) != 0)
				r = 3 * r + (1 << i);
		end
		return r;
	endfunction

	// mask kept only if it has the largest R in its (q, R mod 3^q) class
	function automatic logic allow_f(input int gb, input int a);
		int  qa;
		int  ra;
		int  qb;
		int  rb;
		int  p3;
		logic ok;
		qa = wq_f(gb, a);
		ra = wr_f(gb, a);
		p3 = 1;
		for (int i = 0; i < qa; i++)
			p3 = 3 * p3;
		ok = 1'b1;
		for (int b = 0; b < (1 << gb); b++) begin
			if (b != a) begin
				qb = wq_f(gb, b);
				rb = wr_f(gb, b);
				if (qb == qa && resid_f(rb, p3) == resid_f(ra, p3) &&
				    (rb > ra || (rb == ra && b < a)))
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

/* rtl/cppd_cell.sv */
// One slice of the 128-bit working value; computes its part of x/2 or x + x/2 + 1.
module cppd_cell (
	input  logic                          clk,
	input  cppd_pkg::cell_ctl_t           ctl,
	input  logic [cppd_pkg::CELL_W-1:0]   load_slice,
	input  logic                          hi_lsb,
	input  logic                          carry_in,
	input  logic                          clr_msb,
	output logic [cppd_pkg::CELL_W-1:0]   slice,
	output logic                          carry_out
);

	logic [cppd_pkg::CELL_W-1:0] slice_q;
	logic [cppd_pkg::CELL_W-1:0] shr;
	logic [cppd_pkg::CELL_W:0]   sum;
	logic [cppd_pkg::CELL_W-1:0] nxt;

	always_comb begin
		shr = {hi_lsb, slice_q[cppd_pkg::CELL_W-1:1]};
		sum = {1'b0, slice_q} + {1'b0, shr} + {{cppd_pkg::CELL_W{1'b0}}, carry_in};
		nxt = ctl.odd ? sum[cppd_pkg::CELL_W-1:0] : shr;
		if (clr_msb)
			nxt[cppd_pkg::CELL_W-1] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slice_q <= load_slice;
		end else if (ctl.step) begin
			slice_q <= nxt;
		end
	end

	assign slice     = slice_q;
	assign carry_out = sum[cppd_pkg::CELL_W];

endmodule

/* rtl/collatz_pruned_prefix_depth_top.sv */
// Top level: pruned Collatz prefix depth over a chain of value-slice cells.
//
//  channel | dir | signals                   | beat contents
//  s       | in  | s_tvalid s_tready s_tdata | start_value[63:0]
//  m       | out | m_tvalid m_tready m_tdata | prefix_depth[7:0]
//
// One item at a time: the cells load the start value, then take one half-step per cycle
// unless a finished run stalls on a full output register; the 128-bit
// carry ripple through the cell chain sets the cycle.
// arst_n clears control; the value cells are not reset.
// A finished result sits in the output register, so the next item loads while it waits;
// a run that finishes while that register is still full holds until it drains.
module collatz_pruned_prefix_depth_top #(
	parameter int STEPS_MAX  = 224,
	parameter int GROUP_BITS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cppd_pkg::START_W-1:0]   s_tdata,  // [63:0] start_value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cppd_pkg::DEPTH_W-1:0]   m_tdata   // [7:0] prefix_depth
);

	localparam int KW         = $clog2(STEPS_MAX + 1);
	localparam int GROUP_SIZE = 1 << GROUP_BITS;
	localparam int GPW        = (GROUP_BITS > 1) ? $clog2(GROUP_BITS) : 1;

	logic [KW-1:0] qmin_tab [0:STEPS_MAX];
	logic          allow_tab [0:GROUP_SIZE-1];

	for (genvar g = 0; g <= STEPS_MAX; g++) begin : g_qmin
		assign qmin_tab[g] = KW'(cppd_pkg::qmin_f(g));
	end

	for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_allow
		assign allow_tab[g] = cppd_pkg::allow_f(GROUP_BITS, g);
	end

	cppd_pkg::state_t               state_q, state_d;
	logic [KW-1:0]                  k_q, q_cnt_q;
	logic [GROUP_BITS-1:0]          gmask_q;
	logic [GPW-1:0]                 gpos_q;
	logic                           out_valid_q;
	logic [cppd_pkg::DEPTH_W-1:0]   depth_q;

	cppd_pkg::cell_ctl_t            ctl;
	logic [cppd_pkg::VAL_W-1:0]     value;
	logic [cppd_pkg::N_CELLS:0]     carry;

	logic                           bit0;
	logic [KW-1:0]                  q_nxt, k_inc;
	logic [GROUP_BITS-1:0]          full_mask;
	logic                           grp_done, fail, last, finish, stall, accept;
	logic [cppd_pkg::DEPTH_W-1:0]   depth_d;

	assign bit0     = value[0];
	assign carry[0] = 1'b1;

	for (genvar c = 0; c < cppd_pkg::N_CELLS; c++) begin : g_cell
		logic [cppd_pkg::CELL_W-1:0] ld;
		logic                        hl;
		if ((c + 1) * cppd_pkg::CELL_W <= cppd_pkg::START_W) begin : g_ld
			assign ld = s_tdata[c*cppd_pkg::CELL_W +: cppd_pkg::CELL_W];
		end else begin : g_zero
			assign ld = '0;
		end
		if (c == cppd_pkg::N_CELLS - 1) begin : g_top
			assign hl = 1'b0;
		end else begin : g_mid
			assign hl = value[(c+1)*cppd_pkg::CELL_W];
		end
		cppd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.load_slice (ld),
			.hi_lsb     (hl),
			.carry_in   (carry[c]),
			.clr_msb    (c == cppd_pkg::N_CELLS - 1),
			.slice      (value[c*cppd_pkg::CELL_W +: cppd_pkg::CELL_W]),
			.carry_out  (carry[c+1])
		);
	end

	always_comb begin
		q_nxt = q_cnt_q + KW'(bit0);
		k_inc = k_q + KW'(1);
		for (int i = 0; i < GROUP_BITS; i++)
			full_mask[i] = (GPW'(i) == gpos_q) ? bit0 : gmask_q[i];
		grp_done = gpos_q == GPW'(GROUP_BITS - 1);
		fail     = (q_nxt < qmin_tab[k_inc]) || (grp_done && !allow_tab[full_mask]);
		last     = k_q == KW'(STEPS_MAX - 1);
		depth_d  = fail ? cppd_pkg::DEPTH_W'(k_q) : cppd_pkg::DEPTH_W'(STEPS_MAX);
		accept   = 1'b0;
		finish   = 1'b0;
		stall    = 1'b0;
		ctl      = '0;
		state_d  = state_q;
		case (state_q)
			cppd_pkg::ST_IDLE: begin
				accept   = s_tvalid;
				ctl.load = s_tvalid;
				if (s_tvalid)
					state_d = cppd_pkg::ST_RUN;
			end
			cppd_pkg::ST_RUN: begin
				stall    = (fail || last) && out_valid_q && !m_tready;
				finish   = (fail || last) && !stall;
				ctl.step = !stall;
				ctl.odd  = bit0;
				if (finish)
					state_d = cppd_pkg::ST_IDLE;
			end
			default: begin
				state_d = cppd_pkg::ST_IDLE;
			end
		endcase
	end

	assign s_tready = state_q == cppd_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cppd_pkg::ST_IDLE;
			k_q         <= '0;
			q_cnt_q     <= '0;
			gmask_q     <= '0;
			gpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q     <= '0;
				q_cnt_q <= '0;
				gmask_q <= '0;
				gpos_q  <= '0;
			end else if (ctl.step) begin
				k_q     <= k_inc;
				q_cnt_q <= q_nxt;
				if (grp_done) begin
					gmask_q <= '0;
					gpos_q  <= '0;
				end else begin
					gmask_q <= full_mask;
					gpos_q  <= gpos_q + GPW'(1);
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			depth_q <= depth_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = depth_q;

endmodule
